>>> hw/rtl/cbp_pkg.sv
// Shared constants, types and codes for the capacity bucket placer.
package cbp_pkg;

  // Table geometry
  localparam int NUM_BUCKETS    = 1024;
  localparam int BKT_AW         = $clog2(NUM_BUCKETS);
  localparam int BKT_CW         = $clog2(NUM_BUCKETS + 1);
  localparam int MAX_PER_BUCKET = 256;
  localparam int ITEM_W         = $clog2(MAX_PER_BUCKET + 1);
  localparam int LEN_W          = 16;
  localparam int WGT_W          = 2 * LEN_W;

  // Fixed field widths
  localparam int BUCKET_IDX_W = 10;
  localparam int SLOT_W       = 8;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 16;
  localparam int MODE_W       = 2;
  localparam int BCOUNT_W     = 11;
  localparam int CAP_W        = 16;
  localparam int MAXPB_W      = 9;

  // Placement policy codes (anything else acts as least weight)
  localparam logic [MODE_W-1:0] MODE_FIRST_FIT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ROUND_ROBIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LEAST_WGT   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_BKT  = 4'd3;

  // One bucket record as held in the table memory
  typedef struct packed {
    logic [ITEM_W-1:0] count;
    logic [LEN_W-1:0]  sum_a;
    logic [LEN_W-1:0]  sum_b;
    logic [WGT_W-1:0]  weight;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PREP,
    ST_MOD,
    ST_SCAN,
    ST_COMMIT
  } state_t;

endpackage

>>> hw/rtl/cbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/capacity_bucket_placer_top.sv
// Capacity bucket placer: bucket table in RAM, scan/commit sequencer, config registers.
//
//  Channel  | Handshake                    | Beat contents
//  ---------+------------------------------+-------------------------------------------
//  item in  | start && !busy               | new_batch, a_length, b_length
//  result   | done (one cycle, no stall)   | bucket_index, slot, failed
//  config   | cfg_valid && cfg_ready       | cfg_index, cfg_data
//
//  Reset sweeps the table to zero, one bucket per cycle (busy high); config
//  writes are taken during the sweep; an item with new_batch pays the same sweep first.
//  Search: least weight reads all n buckets in use; first fit reads on from the pointer and
//  stops at the first bucket that fits; round robin first reduces the pointer modulo n by
//  repeated subtraction of n; when nothing can be searched, the search is skipped.
//  The result is registered and appears in the cycle after the bucket write-back; the receiver cannot stall it.
module capacity_bucket_placer_top (
  input  logic                              clk,
  input  logic                              rst,
  // item command
  input  logic                              start,
  output logic                              busy,
  input  logic                              new_batch,
  input  logic [cbp_pkg::LEN_W-1:0]         a_length,
  input  logic [cbp_pkg::LEN_W-1:0]         b_length,
  // result
  output logic                              done,
  output logic [cbp_pkg::BUCKET_IDX_W-1:0]  bucket_index,
  output logic [cbp_pkg::SLOT_W-1:0]        slot,
  output logic                              failed,
  // config write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Config registers
  logic [cbp_pkg::MODE_W-1:0]   mode;
  logic [cbp_pkg::BCOUNT_W-1:0] bucket_count;
  logic [cbp_pkg::CAP_W-1:0]    bucket_capacity;
  logic [cbp_pkg::MAXPB_W-1:0]  max_per_bucket;

  // Sequencer registers
  cbp_pkg::state_t              state, state_next;
  logic [cbp_pkg::BKT_AW-1:0]   clr_addr, clr_addr_next;
  logic                         clr_to_prep, clr_to_prep_next;
  logic [cbp_pkg::BKT_CW-1:0]   ptr, ptr_next;
  logic [cbp_pkg::BKT_CW-1:0]   rr_start, rr_start_next;
  logic [cbp_pkg::BKT_AW-1:0]   scan_addr, scan_addr_next;
  logic [cbp_pkg::BKT_CW-1:0]   scan_left, scan_left_next;
  logic                         rd_pending, rd_pending_next;
  logic [cbp_pkg::BKT_AW-1:0]   rd_addr, rd_addr_next;
  logic                         found, found_next;
  logic [cbp_pkg::BKT_AW-1:0]   chosen, chosen_next;
  cbp_pkg::entry_t              entry, entry_next;
  logic                         done_next;
  logic [cbp_pkg::BUCKET_IDX_W-1:0] bucket_index_next;
  logic [cbp_pkg::SLOT_W-1:0]   slot_next;
  logic                         failed_next;

  // Item payload
  logic [cbp_pkg::LEN_W-1:0]    a_q, b_q;
  logic [cbp_pkg::WGT_W-1:0]    prod;

  // RAM port
  logic                         ram_we, ram_re;
  logic [cbp_pkg::BKT_AW-1:0]   ram_waddr, ram_raddr;
  cbp_pkg::entry_t              ram_wdata, rd_entry;
  logic [$bits(cbp_pkg::entry_t)-1:0] ram_rdata;

  // Derived limits
  logic [cbp_pkg::BKT_CW-1:0]   n_eff;
  logic [cbp_pkg::ITEM_W-1:0]   limit;
  logic                         is_ff, is_rr;
  logic                         accept;
  logic                         fit;
  logic [cbp_pkg::BKT_CW-1:0]   scan_addr_inc, rr_start_inc;
  logic [cbp_pkg::WGT_W:0]      wgt_sum;

  assign accept    = start && !busy;
  assign busy      = (state != cbp_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign n_eff = (cbp_pkg::BKT_CW'(bucket_count) > cbp_pkg::BKT_CW'(cbp_pkg::NUM_BUCKETS))
                 ? cbp_pkg::BKT_CW'(cbp_pkg::NUM_BUCKETS) : cbp_pkg::BKT_CW'(bucket_count);
  assign limit = (cbp_pkg::ITEM_W'(max_per_bucket) > cbp_pkg::ITEM_W'(cbp_pkg::MAX_PER_BUCKET))
                 ? cbp_pkg::ITEM_W'(cbp_pkg::MAX_PER_BUCKET) : cbp_pkg::ITEM_W'(max_per_bucket);
  assign is_ff = (mode == cbp_pkg::MODE_FIRST_FIT);
  assign is_rr = (mode == cbp_pkg::MODE_ROUND_ROBIN);

  // Feasibility of the bucket whose record just came back from RAM
  assign rd_entry = cbp_pkg::entry_t'(ram_rdata);
  assign fit = ((cbp_pkg::ITEM_W+1)'(rd_entry.count) + (cbp_pkg::ITEM_W+1)'(1))
                 <= (cbp_pkg::ITEM_W+1)'(limit)
            && ((cbp_pkg::LEN_W+1)'(rd_entry.sum_a) + (cbp_pkg::LEN_W+1)'(a_q))
                 <= (cbp_pkg::LEN_W+1)'(bucket_capacity)
            && ((cbp_pkg::LEN_W+1)'(rd_entry.sum_b) + (cbp_pkg::LEN_W+1)'(b_q))
                 <= (cbp_pkg::LEN_W+1)'(bucket_capacity);

  assign scan_addr_inc = cbp_pkg::BKT_CW'(scan_addr) + cbp_pkg::BKT_CW'(1);
  assign rr_start_inc  = rr_start + cbp_pkg::BKT_CW'(1);
  assign wgt_sum       = (cbp_pkg::WGT_W+1)'(entry.weight) + (cbp_pkg::WGT_W+1)'(prod);

  cbp_ram #(
    .WIDTH($bits(cbp_pkg::entry_t)),
    .DEPTH(cbp_pkg::NUM_BUCKETS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= cbp_pkg::MODE_FIRST_FIT;
      bucket_count    <= cbp_pkg::BCOUNT_W'(1024);
      bucket_capacity <= cbp_pkg::CAP_W'(65535);
      max_per_bucket  <= cbp_pkg::MAXPB_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cbp_pkg::REG_MODE:         mode            <= cfg_data[cbp_pkg::MODE_W-1:0];
        cbp_pkg::REG_BUCKET_COUNT: bucket_count    <= cfg_data[cbp_pkg::BCOUNT_W-1:0];
        cbp_pkg::REG_CAPACITY:     bucket_capacity <= cfg_data[cbp_pkg::CAP_W-1:0];
        cbp_pkg::REG_MAX_PER_BKT:  max_per_bucket  <= cfg_data[cbp_pkg::MAXPB_W-1:0];
        default: ;
      endcase
    end
  end

  // Item payload capture; product registered ahead of the weight add
  always_ff @(posedge clk) begin
    if (accept) begin
      a_q  <= a_length;
      b_q  <= b_length;
      prod <= cbp_pkg::WGT_W'(a_length) * cbp_pkg::WGT_W'(b_length);
    end
  end

  // Sequencer state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cbp_pkg::ST_CLEAR;
      clr_addr    <= '0;
      clr_to_prep <= 1'b0;
      ptr         <= '0;
      rd_pending  <= 1'b0;
      found       <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      clr_addr    <= clr_addr_next;
      clr_to_prep <= clr_to_prep_next;
      ptr         <= ptr_next;
      rd_pending  <= rd_pending_next;
      found       <= found_next;
      done        <= done_next;
    end
    rr_start     <= rr_start_next;
    scan_addr    <= scan_addr_next;
    scan_left    <= scan_left_next;
    rd_addr      <= rd_addr_next;
    chosen       <= chosen_next;
    entry        <= entry_next;
    bucket_index <= bucket_index_next;
    slot         <= slot_next;
    failed       <= failed_next;
  end

  // Next state, RAM control and result
  always_comb begin
    state_next        = state;
    clr_addr_next     = clr_addr;
    clr_to_prep_next  = clr_to_prep;
    ptr_next          = ptr;
    rr_start_next     = rr_start;
    scan_addr_next    = scan_addr;
    scan_left_next    = scan_left;
    rd_pending_next   = 1'b0;
    rd_addr_next      = rd_addr;
    found_next        = found;
    chosen_next       = chosen;
    entry_next        = entry;
    done_next         = 1'b0;
    bucket_index_next = bucket_index;
    slot_next         = slot;
    failed_next       = failed;
    ram_we            = 1'b0;
    ram_waddr         = clr_addr;
    ram_wdata         = '0;
    ram_re            = 1'b0;
    ram_raddr         = scan_addr;

    case (state)
      cbp_pkg::ST_IDLE: begin
        if (accept) begin
          if (new_batch) begin
            ptr_next         = '0;
            clr_addr_next    = '0;
            clr_to_prep_next = 1'b1;
            state_next       = cbp_pkg::ST_CLEAR;
          end else begin
            state_next = cbp_pkg::ST_PREP;
          end
        end
      end

      // Zero sweep, one bucket per cycle
      cbp_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == cbp_pkg::BKT_AW'(cbp_pkg::NUM_BUCKETS - 1)) begin
          state_next       = clr_to_prep ? cbp_pkg::ST_PREP : cbp_pkg::ST_IDLE;
          clr_to_prep_next = 1'b0;
        end else begin
          clr_addr_next = clr_addr + cbp_pkg::BKT_AW'(1);
        end
      end

      // Pick the scan window for the mode
      cbp_pkg::ST_PREP: begin
        found_next = 1'b0;
        if (n_eff == '0 || limit == '0) begin
          state_next = cbp_pkg::ST_COMMIT;
        end else if (is_ff) begin
          if (ptr >= n_eff) begin
            state_next = cbp_pkg::ST_COMMIT;
          end else begin
            scan_addr_next = ptr[cbp_pkg::BKT_AW-1:0];
            scan_left_next = n_eff - ptr;
            state_next     = cbp_pkg::ST_SCAN;
          end
        end else if (is_rr) begin
          rr_start_next = ptr;
          state_next    = cbp_pkg::ST_MOD;
        end else begin
          scan_addr_next = '0;
          scan_left_next = n_eff;
          state_next     = cbp_pkg::ST_SCAN;
        end
      end

      // Round-robin start: pointer reduced modulo n by repeated subtraction
      cbp_pkg::ST_MOD: begin
        if (rr_start >= n_eff) begin
          rr_start_next = rr_start - n_eff;
        end else begin
          scan_addr_next = rr_start[cbp_pkg::BKT_AW-1:0];
          scan_left_next = n_eff;
          state_next     = cbp_pkg::ST_SCAN;
        end
      end

      // One read issued and one record checked per cycle
      cbp_pkg::ST_SCAN: begin
        if (rd_pending && fit && !is_ff && !is_rr) begin
          if (!found || rd_entry.weight < entry.weight) begin
            found_next  = 1'b1;
            chosen_next = rd_addr;
            entry_next  = rd_entry;
          end
        end
        if (rd_pending && fit && (is_ff || is_rr)) begin
          found_next  = 1'b1;
          chosen_next = rd_addr;
          entry_next  = rd_entry;
          state_next  = cbp_pkg::ST_COMMIT;
        end else if (scan_left != '0) begin
          ram_re          = 1'b1;
          ram_raddr       = scan_addr;
          rd_pending_next = 1'b1;
          rd_addr_next    = scan_addr;
          scan_addr_next  = (scan_addr_inc == n_eff) ? '0
                            : scan_addr_inc[cbp_pkg::BKT_AW-1:0];
          scan_left_next  = scan_left - cbp_pkg::BKT_CW'(1);
        end else if (!rd_pending) begin
          state_next = cbp_pkg::ST_COMMIT;
        end
      end

      // Write back the chosen bucket and present the result
      cbp_pkg::ST_COMMIT: begin
        done_next  = 1'b1;
        state_next = cbp_pkg::ST_IDLE;
        if (found) begin
          ram_we           = 1'b1;
          ram_waddr        = chosen;
          ram_wdata.count  = entry.count + cbp_pkg::ITEM_W'(1);
          ram_wdata.sum_a  = entry.sum_a + a_q;
          ram_wdata.sum_b  = entry.sum_b + b_q;
          ram_wdata.weight = wgt_sum[cbp_pkg::WGT_W] ? '1 : wgt_sum[cbp_pkg::WGT_W-1:0];
          bucket_index_next = cbp_pkg::BUCKET_IDX_W'(chosen);
          slot_next         = entry.count[cbp_pkg::SLOT_W-1:0];
          failed_next       = 1'b0;
          if (is_ff) begin
            ptr_next = cbp_pkg::BKT_CW'(chosen);
          end else if (is_rr) begin
            ptr_next = (rr_start_inc == n_eff) ? '0 : rr_start_inc;
          end
        end else begin
          bucket_index_next = '0;
          slot_next         = '0;
          failed_next       = 1'b1;
          if (is_ff) begin
            ptr_next = n_eff;
          end
        end
      end

      default: begin
        state_next = cbp_pkg::ST_IDLE;
      end
    endcase
  end

  // Checks
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && failed |-> bucket_index == '0 && slot == '0)
    else $error("failed result carries nonzero bucket or slot");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !ram_re)
    else $error("table read issued during write-back or sweep");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted item did not make the block busy");

  a_rr_ptr_range: assert property (@(posedge clk) disable iff (rst)
    done && !failed && is_rr |-> ptr < n_eff)
    else $error("round-robin pointer left outside buckets in use");

  a_scan_found: assert property (@(posedge clk) disable iff (rst)
    state == cbp_pkg::ST_COMMIT && found |-> chosen < n_eff[cbp_pkg::BKT_AW-1:0]
      || n_eff == cbp_pkg::BKT_CW'(cbp_pkg::NUM_BUCKETS))
    else $error("chosen bucket outside buckets in use");

endmodule
